// ===== rtl/tlvp_pkg.sv =====
// Package for the type-length-value option parser.
// Shared types, codes and the type classification function; no dependencies.
package tlvp_pkg;

  localparam int USER_LENGTH_BYTES = 4;
  localparam int PORT_BYTES        = 2;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CL_OTHER  = 3'd0,
    CL_DOMAIN = 3'd1,
    CL_PORT   = 3'd2,
    CL_USER   = 3'd3,
    CL_END    = 3'd4
  } cls_t;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_DOM_LEN  = 3'd1;
  localparam logic [2:0] KIND_DOM_BYTE = 3'd2;
  localparam logic [2:0] KIND_PORT     = 3'd3;
  localparam logic [2:0] KIND_USER_LEN = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;

  localparam logic [1:0] ST_END_SEEN = 2'd0;
  localparam logic [1:0] ST_NO_END   = 2'd1;
  localparam logic [1:0] ST_CUT      = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  localparam logic [1:0] REG_DOMAIN_TYPE = 2'd0;
  localparam logic [1:0] REG_PORT_TYPE   = 2'd1;
  localparam logic [1:0] REG_USER_TYPE   = 2'd2;
  localparam logic [1:0] REG_END_TYPE    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tlvp_in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] result_value;
    logic        last_domain_byte;
    logic        frame_done;
    logic [1:0]  frame_status;
  } tlvp_out_t;

  typedef struct packed {
    logic [7:0] domain_type_code;
    logic [7:0] port_type_code;
    logic [7:0] user_length_type_code;
    logic [7:0] end_type_code;
  } type_codes_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  opt_type;
    logic [7:0]  remaining;
    logic [7:0]  value_index;
    logic [31:0] acc;
    logic        short_seen;
  } parse_state_t;

  function automatic cls_t classify(input logic [7:0] t, input type_codes_t c);
    cls_t r;
    if (t == c.domain_type_code) r = CL_DOMAIN;
    else if (t == c.port_type_code) r = CL_PORT;
    else if (t == c.user_length_type_code) r = CL_USER;
    else if (t == c.end_type_code) r = CL_END;
    else r = CL_OTHER;
    return r;
  endfunction

endpackage

// ===== rtl/tlvp_step.sv =====
// Per-byte parse step: next parser state and the result for one buffer byte.
// Purely combinational; uses tlvp_pkg.
module tlvp_step import tlvp_pkg::*; (
  input  parse_state_t st,
  input  type_codes_t  codes,
  input  tlvp_in_t     item,
  output parse_state_t st_nxt,
  output logic         emit,
  output tlvp_out_t    res
);

  cls_t         cls_b;
  cls_t         cls_cur;
  parse_state_t s;
  logic         cut;
  logic [7:0]   rem_dec;
  logic [7:0]   idx_inc;

  assign cls_b   = classify(item.data_byte, codes);
  assign cls_cur = classify(st.opt_type, codes);
  assign rem_dec = st.remaining - 8'd1;
  assign idx_inc = st.value_index + {7'd0, (st.value_index != 8'hFF)};

  always_comb begin
    s    = st;
    cut  = 1'b0;
    emit = 1'b0;
    res  = '0;
    case (st.phase)
      PH_TYPE: begin
        s.opt_type = item.data_byte;
        if (cls_b == CL_END) begin
          res.result_kind = KIND_END;
          emit            = 1'b1;
          s.phase         = PH_DONE;
        end else begin
          s.phase = PH_LEN;
          cut     = item.last_byte;
        end
      end
      PH_LEN: begin
        s.remaining   = item.data_byte;
        s.value_index = '0;
        s.acc         = '0;
        if (cls_cur == CL_DOMAIN) begin
          res.result_kind  = KIND_DOM_LEN;
          res.result_value = {24'd0, item.data_byte};
          emit             = 1'b1;
        end
        if (item.data_byte == 8'd0) begin
          if (cls_cur == CL_PORT || cls_cur == CL_USER) s.short_seen = 1'b1;
          s.phase = PH_TYPE;
        end else begin
          s.phase = PH_VAL;
          cut     = item.last_byte;
        end
      end
      PH_VAL: begin
        s.remaining = rem_dec;
        if (cls_cur == CL_DOMAIN) begin
          res.result_kind      = KIND_DOM_BYTE;
          res.result_value     = {24'd0, item.data_byte};
          res.last_domain_byte = (rem_dec == 8'd0);
          emit                 = 1'b1;
        end else if (cls_cur == CL_PORT) begin
          if (st.value_index < 8'(PORT_BYTES))
            s.acc = {16'd0, st.acc[7:0], item.data_byte};
        end else if (cls_cur == CL_USER) begin
          if (st.value_index < 8'(USER_LENGTH_BYTES)) begin
            case (st.value_index[1:0])
              2'd0:    s.acc[7:0]   = st.acc[7:0]   | item.data_byte;
              2'd1:    s.acc[15:8]  = st.acc[15:8]  | item.data_byte;
              2'd2:    s.acc[23:16] = st.acc[23:16] | item.data_byte;
              default: s.acc[31:24] = st.acc[31:24] | item.data_byte;
            endcase
          end
        end
        s.value_index = idx_inc;
        if (rem_dec == 8'd0) begin
          if (cls_cur == CL_PORT) begin
            if (idx_inc >= 8'(PORT_BYTES)) begin
              res.result_kind  = KIND_PORT;
              res.result_value = s.acc;
              emit             = 1'b1;
            end else begin
              s.short_seen = 1'b1;
            end
          end else if (cls_cur == CL_USER) begin
            if (idx_inc >= 8'(USER_LENGTH_BYTES)) begin
              res.result_kind  = KIND_USER_LEN;
              res.result_value = s.acc;
              emit             = 1'b1;
            end else begin
              s.short_seen = 1'b1;
            end
          end
          s.phase = PH_TYPE;
        end else begin
          cut = item.last_byte;
        end
      end
      default: begin
      end
    endcase

    st_nxt = s;
    if (item.last_byte) begin
      res.frame_done = 1'b1;
      if (cut) res.frame_status = ST_CUT;
      else if (s.short_seen) res.frame_status = ST_SHORT;
      else if (s.phase == PH_DONE) res.frame_status = ST_END_SEEN;
      else res.frame_status = ST_NO_END;
      emit   = 1'b1;
      st_nxt = '{phase: PH_TYPE, default: '0};
    end
  end

endmodule

// ===== rtl/tlv_option_field_parser.sv =====
// Top level of the type-length-value option parser: input register, parser
// state, type code registers and result register. Uses tlvp_pkg and tlvp_step.
//
// Takes one option buffer byte per cycle while in_stall is low, flagged on the
// buffer's last byte, and returns at most one result per byte; a byte passes
// through the input register, then the parse step into the result register.
// in_stall is raised only while the result register is full and stalled and
// the byte in the input register has a result to deliver. The user must write
// type codes through cfg_* only while no bytes are in flight; the block itself
// does not enforce this.
module tlv_option_field_parser import tlvp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  tlvp_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tlvp_out_t  out_data
);

  type_codes_t  codes_r;
  logic         s1_valid_r;
  tlvp_in_t     s1_data_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         out_valid_r;
  tlvp_out_t    out_data_r;
  logic         step_emit;
  tlvp_out_t    step_res;
  logic         advance;
  logic         out_free;
  logic         in_take;

  tlvp_step u_step (
    .st     (state_r),
    .codes  (codes_r),
    .item   (s1_data_r),
    .st_nxt (state_nxt),
    .emit   (step_emit),
    .res    (step_res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!step_emit || out_free);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= '{domain_type_code: 8'd1, port_type_code: 8'd2,
                   user_length_type_code: 8'd3, end_type_code: 8'd0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOMAIN_TYPE: codes_r.domain_type_code      <= cfg_wdata;
        REG_PORT_TYPE:   codes_r.port_type_code        <= cfg_wdata;
        REG_USER_TYPE:   codes_r.user_length_type_code <= cfg_wdata;
        REG_END_TYPE:    codes_r.end_type_code         <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '{phase: PH_TYPE, default: '0};
    end else begin
      if (in_take) s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) out_data_r <= step_res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_data_r.last_byte) |=> (state_r.phase == PH_TYPE && !state_r.short_seen))
    else $error("parser state not cleared after buffer end");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.frame_done) |-> (out_data_r.frame_status == ST_END_SEEN))
    else $error("frame status on a result that does not close the buffer");

  a_ldb_domain_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_domain_byte) |-> (out_data_r.result_kind == KIND_DOM_BYTE))
    else $error("last domain byte mark on a non-domain result");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");
`endif

endmodule

// ===== sim/tlvp_checker.sv =====
`timescale 1ns / 100ps
// Checker for tlv_option_field_parser: tracks type code writes, predicts each result
// from accepted request bytes and compares delivered results. Uses tlvp_pkg.
module tlvp_checker import tlvp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  tlvp_in_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  tlvp_out_t  out_data,
  output int         fail_count,
  output int         pending
);

  logic [7:0]  dom_code, port_code, user_code, end_code;
  phase_t      ph;
  logic [7:0]  opt_type, remaining, vidx;
  logic [31:0] acc;
  logic        short_seen;
  tlvp_out_t   results_q[$];
  tlvp_out_t   want;
  int          n_fail = 0;
  int          n_pending = 0;

  assign fail_count = n_fail;
  assign pending    = n_pending;

  function automatic cls_t code_class(input logic [7:0] t);
    if (t == dom_code) return CL_DOMAIN;
    if (t == port_code) return CL_PORT;
    if (t == user_code) return CL_USER;
    if (t == end_code) return CL_END;
    return CL_OTHER;
  endfunction

  task automatic clear_parse();
    ph         = PH_TYPE;
    opt_type   = 8'd0;
    remaining  = 8'd0;
    vidx       = 8'd0;
    acc        = 32'd0;
    short_seen = 1'b0;
  endtask

  task automatic predict_byte(input tlvp_in_t b);
    tlvp_out_t r;
    cls_t      c;
    logic      cut;
    logic      emit;
    r    = '0;
    cut  = 1'b0;
    emit = 1'b0;
    case (ph)
      PH_TYPE: begin
        opt_type = b.data_byte;
        if (code_class(b.data_byte) == CL_END) begin
          r.result_kind = KIND_END;
          emit = 1'b1;
          ph = PH_DONE;
        end else begin
          ph = PH_LEN;
          cut = b.last_byte;
        end
      end
      PH_LEN: begin
        c = code_class(opt_type);
        remaining = b.data_byte;
        vidx = 8'd0;
        acc = 32'd0;
        if (c == CL_DOMAIN) begin
          r.result_kind = KIND_DOM_LEN;
          r.result_value = {24'd0, b.data_byte};
          emit = 1'b1;
        end
        if (b.data_byte == 8'd0) begin
          if (c == CL_PORT || c == CL_USER) short_seen = 1'b1;
          ph = PH_TYPE;
        end else begin
          ph = PH_VAL;
          cut = b.last_byte;
        end
      end
      PH_VAL: begin
        c = code_class(opt_type);
        remaining = remaining - 8'd1;
        case (c)
          CL_DOMAIN: begin
            r.result_kind = KIND_DOM_BYTE;
            r.result_value = {24'd0, b.data_byte};
            r.last_domain_byte = (remaining == 8'd0);
            emit = 1'b1;
          end
          CL_PORT: if (vidx < PORT_BYTES) acc = {16'd0, acc[7:0], b.data_byte};
          CL_USER: if (vidx < USER_LENGTH_BYTES) acc = acc | (32'(b.data_byte) << (8 * vidx));
          default: ;
        endcase
        if (vidx != 8'hFF) vidx = vidx + 8'd1;
        if (remaining == 8'd0) begin
          if (c == CL_PORT) begin
            if (vidx >= PORT_BYTES) begin
              r.result_kind = KIND_PORT;
              r.result_value = acc;
              emit = 1'b1;
            end else short_seen = 1'b1;
          end else if (c == CL_USER) begin
            if (vidx >= USER_LENGTH_BYTES) begin
              r.result_kind = KIND_USER_LEN;
              r.result_value = acc;
              emit = 1'b1;
            end else short_seen = 1'b1;
          end
          ph = PH_TYPE;
        end else if (b.last_byte) begin
          cut = 1'b1;
        end
      end
      default: ;
    endcase
    if (b.last_byte) begin
      r.frame_done = 1'b1;
      if (cut) r.frame_status = ST_CUT;
      else if (short_seen) r.frame_status = ST_SHORT;
      else if (ph == PH_DONE) r.frame_status = ST_END_SEEN;
      else r.frame_status = ST_NO_END;
      emit = 1'b1;
      clear_parse();
    end
    if (emit) results_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dom_code  = 8'd1;
      port_code = 8'd2;
      user_code = 8'd3;
      end_code  = 8'd0;
      clear_parse();
      results_q.delete();
      n_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOMAIN_TYPE: dom_code  = cfg_wdata;
          REG_PORT_TYPE:   port_code = cfg_wdata;
          REG_USER_TYPE:   user_code = cfg_wdata;
          REG_END_TYPE:    end_code  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (results_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, got %0h", $time, out_data);
        end else begin
          want = results_q.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_data.result_kind));
          check_field("result_value", want.result_value, out_data.result_value);
          check_field("last_domain_byte", 32'(want.last_domain_byte),
                      32'(out_data.last_domain_byte));
          check_field("frame_done", 32'(want.frame_done), 32'(out_data.frame_done));
          check_field("frame_status", 32'(want.frame_status), 32'(out_data.frame_status));
        end
      end
      if (in_valid && !in_stall) predict_byte(in_data);
      n_pending <= results_q.size();
    end
  end

endmodule

// ===== sim/tlv_option_field_parser_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for tlv_option_field_parser: clock, reset, type code writes and
// option buffer stimulus with random idling. Uses tlvp_pkg and tlvp_checker.
module tlv_option_field_parser_tb import tlvp_pkg::*;;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_DOMAIN_TYPE;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  tlvp_in_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  tlvp_out_t  out_data;
  int         fail_count;
  int         pending;

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_reqs = 0;
  int         n_sent = 0;
  logic [7:0] dom_code = 8'd1, port_code = 8'd2, user_code = 8'd3, end_code = 8'd0;
  logic [7:0] frame_q[$];

  tlv_option_field_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tlvp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_reqs != hold_done) begin
        hold_done++;
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_codes(input logic [7:0] d, input logic [7:0] p,
                             input logic [7:0] u, input logic [7:0] e);
    dom_code = d;
    port_code = p;
    user_code = u;
    end_code = e;
    cfg_we <= 1'b1;
    cfg_index <= REG_DOMAIN_TYPE;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_index <= REG_PORT_TYPE;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= REG_USER_TYPE;
    cfg_wdata <= u;
    @(posedge clk);
    cfg_index <= REG_END_TYPE;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame();
    tlvp_in_t item;
    foreach (frame_q[i]) begin
      item.data_byte = frame_q[i];
      item.last_byte = (i == frame_q.size() - 1);
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      n_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly well-formed option lists; some cut short, some raw noise
  task automatic build_frame();
    int         mode;
    int         len;
    int         cut_at;
    logic [7:0] tcode;
    frame_q.delete();
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 7))
          0, 1: begin
            tcode = dom_code;
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
          end
          2, 3: begin
            tcode = port_code;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 4);
          end
          4, 5: begin
            tcode = user_code;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 6);
          end
          default: begin
            tcode = 8'($urandom);
            len = $urandom_range(0, 5);
          end
        endcase
        frame_q.push_back(tcode);
        frame_q.push_back(8'(len));
        repeat (len) frame_q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) < 7) begin
        frame_q.push_back(end_code);
        repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
      end
      if (mode < 4) begin
        cut_at = $urandom_range(0, frame_q.size() - 1);
        while (frame_q.size() > cut_at + 1) void'(frame_q.pop_back());
      end
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset codes: every option kind, bytes after the end marker
    frame_q = '{8'h01, 8'h03, 8'h61, 8'h62, 8'h63, 8'h02, 8'h02, 8'h12, 8'h34,
                8'h03, 8'h04, 8'h78, 8'h56, 8'h34, 8'h12, 8'h00, 8'hFF, 8'h00};
    send_frame();
    // short port value
    frame_q = '{8'h02, 8'h01, 8'hAA};
    send_frame();
    // buffer ends right after a type byte
    frame_q = '{8'h07};
    send_frame();
    // empty domain name, end marker on the last byte
    frame_q = '{8'h01, 8'h00, 8'h00};
    send_frame();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_codes(8'd1, 8'd2, 8'd3, 8'd0);
        1: write_codes(8'hFF, 8'h00, 8'h80, 8'h7F);
        2: write_codes(8'h00, 8'hFF, 8'hFF, 8'h01);
        4: write_codes(8'h55, 8'hAA, 8'h55, 8'h55);
        default: write_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      send_idle_pct = (p < 2) ? 23 : (p < 4) ? 62 : 0;
      recv_idle_pct = (p < 2) ? 62 : (p < 4) ? 23 : 0;
      if (p == 4) hold_reqs++;
      target = 25 + (p + 1) * 275;
      while (n_sent < target) begin
        build_frame();
        send_frame();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tlvp_pkg.sv
rtl/tlvp_step.sv
rtl/tlv_option_field_parser.sv
sim/tlvp_checker.sv
sim/tlv_option_field_parser_tb.sv
